// File: rtl/udf_pkg.sv
// ----------------------------------------------------------------------------
// udf_pkg: shared types and constants of the packet deframer
// Phase codes, register indexes and the byte type of the data cells.
// ----------------------------------------------------------------------------
package udf_pkg;

  typedef logic [7:0] byte_t;

  // Deframer phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SECOND,
    PH_TYPE,
    PH_LENGTH,
    PH_DATA,
    PH_TRAILER,
    PH_ALIGN,
    PH_EMIT
  } phase_t;

  // Configuration register indexes
  localparam logic [2:0] REG_START_FIRST    = 3'd0;
  localparam logic [2:0] REG_START_SECOND   = 3'd1;
  localparam logic [2:0] REG_TRAILER_VALUE  = 3'd2;
  localparam logic [2:0] REG_LENGTH_LIMIT   = 3'd3;
  localparam logic [2:0] REG_CONFIRM_ENABLE = 3'd4;
  localparam logic [2:0] REG_OK_TYPE_CODE   = 3'd5;

  // Second start byte: compare with the ack bit masked off
  localparam byte_t START_MASK = 8'hFE;

endpackage

// File: rtl/udf_cell.sv
// ----------------------------------------------------------------------------
// udf_cell: one byte cell of the data chain
// Holds one data byte and takes its neighbor's byte on each shift.
// ----------------------------------------------------------------------------
module udf_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  udf_pkg::byte_t din,
  output udf_pkg::byte_t dout
);
  import udf_pkg::*;

  byte_t data_r;

  // Take the neighbor's byte on a shift, hold otherwise
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= din;
    end
  end

  assign dout = data_r;

endmodule

// File: rtl/uart_packet_deframer.sv
// ----------------------------------------------------------------------------
// uart_packet_deframer: frames packets from received link bytes
// Header checks, a row of byte cells for the data and a registered result.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one received byte per item. Packets
// are start byte 1, start byte 2, type, length, data, trailer. in_ready is
// high while the block is framing. Data bytes shift into a row of MAX_DATA
// byte cells from the tail end. After a matching trailer the block stops
// taking bytes. For a data packet it first shifts the row so the first data
// byte sits in the head cell, then gives one result item per data byte, one
// per cycle while out_ready is high, popping the head cell each time. A
// confirm or empty packet gives one result item. Data results are read from
// the cell row's single head tap. Results leave through an output register;
// a stalled receiver holds that register and the emitting sequence. Each
// result appears in the cycle after it is generated. A trailer that does not
// match drops the packet silently. Reset (rst_n low, synchronous) returns to
// hunting the first start byte and loads the register defaults; the data
// cells are not cleared. Configuration writes via cfg_we/cfg_index/cfg_wdata
// take effect at once.
// ----------------------------------------------------------------------------
module uart_packet_deframer #(
  parameter int MAX_DATA = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  // byte input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_is_confirm,
  output logic                out_ack_requested,
  output logic [7:0]          out_packet_type,
  output logic [5:0]          out_packet_length,
  output logic                out_has_data,
  output logic [7:0]          out_data_byte,
  output logic [4:0]          out_byte_index,
  output logic                out_last
);
  import udf_pkg::*;

  localparam int CW = $clog2(MAX_DATA + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DATA);
  localparam logic [6:0]    MAX_LIM = 7'(MAX_DATA);

  // Configuration registers
  byte_t      start_first_r, start_second_r, trailer_value_r, ok_type_code_r;
  logic [5:0] length_limit_r;
  logic       confirm_enable_r;

  // Framing state
  phase_t     phase_r, phase_nxt;
  byte_t      held_second_r, held_second_nxt;
  byte_t      held_type_r, held_type_nxt;
  logic [5:0] held_length_r, held_length_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic       single_r, single_nxt;
  logic       single_conf_r, single_conf_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic       out_is_confirm_r, out_ack_r, out_has_data_r, out_last_r;
  byte_t      out_type_r, out_data_r;
  logic [5:0] out_length_r;
  logic [4:0] out_index_r;

  // Chain and control
  byte_t      cell_q [MAX_DATA];
  logic       shift_en;
  logic       in_acc;
  logic       load;
  logic       gen_valid;
  logic       gen_last;
  logic       gen_has;
  logic       gen_conf;
  logic [6:0] limit;
  logic [CW-1:0] len_c;
  logic [CW-1:0] pad;
  logic       trailer_ok;
  logic       head_ok;

  assign in_acc = in_valid && in_ready;
  assign load   = !out_valid_r || out_ready;
  assign len_c  = CW'(held_length_r);
  assign pad    = MAX_CNT - len_c;
  assign limit  = ({1'b0, length_limit_r} > MAX_LIM) ? MAX_LIM : {1'b0, length_limit_r};
  assign head_ok = ((held_second_r & START_MASK) == start_second_r)
                   && (in_rx_byte <= 8'(limit));
  assign trailer_ok = (in_rx_byte == trailer_value_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_first_r    <= 8'h55;
      start_second_r   <= 8'hAA;
      trailer_value_r  <= 8'h45;
      length_limit_r   <= 6'd32;
      confirm_enable_r <= 1'b1;
      ok_type_code_r   <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_FIRST:    start_first_r    <= cfg_wdata;
        REG_START_SECOND:   start_second_r   <= cfg_wdata;
        REG_TRAILER_VALUE:  trailer_value_r  <= cfg_wdata;
        REG_LENGTH_LIMIT:   length_limit_r   <= cfg_wdata[5:0];
        REG_CONFIRM_ENABLE: confirm_enable_r <= cfg_wdata[0];
        REG_OK_TYPE_CODE:   ok_type_code_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next phase and held header fields
  always_comb begin
    phase_nxt       = phase_r;
    held_second_nxt = held_second_r;
    held_type_nxt   = held_type_r;
    held_length_nxt = held_length_r;
    cnt_nxt         = cnt_r;
    single_nxt      = single_r;
    single_conf_nxt = single_conf_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (in_acc && in_rx_byte == start_first_r) begin
          phase_nxt = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (in_acc) begin
          held_second_nxt = in_rx_byte;
          phase_nxt       = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (in_acc) begin
          held_type_nxt = in_rx_byte;
          phase_nxt     = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (in_acc) begin
          if (!head_ok) begin
            phase_nxt = PH_HUNT;
          end else begin
            held_length_nxt = in_rx_byte[5:0];
            cnt_nxt         = '0;
            phase_nxt       = (in_rx_byte == 8'd0) ? PH_TRAILER : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (in_acc) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r + 1'b1 >= len_c) begin
            phase_nxt = PH_TRAILER;
          end
        end
      end
      PH_TRAILER: begin
        if (in_acc) begin
          phase_nxt = PH_HUNT;
          if (trailer_ok) begin
            if (confirm_enable_r && held_type_r == ok_type_code_r) begin
              single_nxt      = 1'b1;
              single_conf_nxt = 1'b1;
              phase_nxt       = PH_EMIT;
            end else if (held_length_r == 6'd0) begin
              single_nxt      = 1'b1;
              single_conf_nxt = 1'b0;
              phase_nxt       = PH_EMIT;
            end else begin
              single_nxt      = 1'b0;
              single_conf_nxt = 1'b0;
              cnt_nxt         = pad;
              phase_nxt       = (pad == '0) ? PH_EMIT : PH_ALIGN;
            end
          end
        end
      end
      PH_ALIGN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          phase_nxt = PH_EMIT;
        end
      end
      PH_EMIT: begin
        if (load) begin
          if (single_r || cnt_r == len_c - 1'b1) begin
            phase_nxt = PH_HUNT;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // Phase outputs: input ready, chain shift, result generation
  always_comb begin
    in_ready  = 1'b0;
    shift_en  = 1'b0;
    gen_valid = 1'b0;
    gen_has   = 1'b0;
    gen_conf  = 1'b0;
    gen_last  = 1'b0;
    unique case (phase_r) inside
      PH_HUNT, PH_SECOND, PH_TYPE, PH_LENGTH, PH_TRAILER: begin
        in_ready = 1'b1;
      end
      PH_DATA: begin
        in_ready = 1'b1;
        shift_en = in_acc;
      end
      PH_ALIGN: begin
        shift_en = 1'b1;
      end
      PH_EMIT: begin
        gen_valid = load;
        gen_has   = !single_r;
        gen_conf  = single_r && single_conf_r;
        gen_last  = single_r || (cnt_r == len_c - 1'b1);
        shift_en  = load && !single_r;
      end
      default: ;
    endcase
  end

  // Phase and header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      held_second_r <= '0;
      held_type_r   <= '0;
      held_length_r <= '0;
      cnt_r         <= '0;
      single_r      <= 1'b0;
      single_conf_r <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      held_second_r <= held_second_nxt;
      held_type_r   <= held_type_nxt;
      held_length_r <= held_length_nxt;
      cnt_r         <= cnt_nxt;
      single_r      <= single_nxt;
      single_conf_r <= single_conf_nxt;
    end
  end

  // Row of data cells: shift toward the head, new bytes enter at the tail
  for (genvar i = 0; i < MAX_DATA; i++) begin : g_cell
    byte_t din;
    if (i == MAX_DATA - 1) begin : g_tail
      assign din = in_rx_byte;
    end else begin : g_mid
      assign din = cell_q[i+1];
    end
    udf_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .din      (din),
      .dout     (cell_q[i])
    );
  end

  // Output valid: set on a generated result, clear when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (gen_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload: load with each generated result
  always_ff @(posedge clk) begin
    if (gen_valid) begin
      out_is_confirm_r <= gen_conf;
      out_ack_r        <= held_second_r[0];
      out_type_r       <= held_type_r;
      out_length_r     <= held_length_r;
      out_has_data_r   <= gen_has;
      out_data_r       <= gen_has ? cell_q[0] : 8'd0;
      out_index_r      <= gen_has ? 5'(cnt_r) : 5'd0;
      out_last_r       <= gen_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_confirm    = out_is_confirm_r;
  assign out_ack_requested = out_ack_r;
  assign out_packet_type   = out_type_r;
  assign out_packet_length = out_length_r;
  assign out_has_data      = out_has_data_r;
  assign out_data_byte     = out_data_r;
  assign out_byte_index    = out_index_r;
  assign out_last          = out_last_r;

endmodule
